[src/utf8v_pkg.sv]
// shared types, constants and code point checks for the utf8 stream validator
`timescale 1ns / 1ps

package utf8v_pkg;

    localparam int BYTE_W   = 8;
    localparam int OFFSET_W = 16;
    localparam int CP_W     = 21;

    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_TWO   = 2'd1;
    localparam logic [1:0] KIND_THREE = 2'd2;
    localparam logic [1:0] KIND_FOUR  = 2'd3;

    localparam logic [CP_W-1:0] CP_MIN_THREE = CP_W'(1 << 11);
    localparam logic [CP_W-1:0] CP_MIN_FOUR  = CP_W'(1 << 16);
    localparam logic [CP_W-1:0] CP_LIMIT     = CP_W'(32'h110000);
    localparam logic [CP_W-1:0] CP_NONCHAR_LO = CP_W'(32'hFDD0);
    localparam logic [CP_W-1:0] CP_NONCHAR_HI = CP_W'(32'hFDEF);
    localparam logic [9:0]      SURROGATE_HI  = 10'h01B;

    typedef struct packed {
        logic                string_valid;
        logic [OFFSET_W-1:0] stop_offset;
        logic                ended_by_nul;
    } t_result;

    function automatic logic cp_ok(input logic [CP_W-1:0] v, input logic [1:0] kind);
        logic [CP_W-1:0] low;
        logic            ok;
        low = (kind == KIND_FOUR) ? CP_MIN_FOUR : CP_MIN_THREE;
        ok  = 1'b1;
        if (v < low) ok = 1'b0;
        if (v >= CP_LIMIT) ok = 1'b0;
        if (v[CP_W-1:11] == SURROGATE_HI) ok = 1'b0;
        if (v >= CP_NONCHAR_LO && v <= CP_NONCHAR_HI) ok = 1'b0;
        if (&v[15:1]) ok = 1'b0;
        return ok;
    endfunction

endpackage

[src/utf8v_if.sv]
// byte and result channel interfaces of the utf8 stream validator
`timescale 1ns / 1ps

interface utf8v_byte_if;
    logic                         valid;
    logic                         ready;
    logic [utf8v_pkg::BYTE_W-1:0] data_byte;
    logic                         last_byte;

    modport source (output valid, output data_byte, output last_byte, input ready);
    modport sink   (input valid, input data_byte, input last_byte, output ready);
endinterface

interface utf8v_result_if;
    logic                           valid;
    logic                           ready;
    logic                           string_valid;
    logic [utf8v_pkg::OFFSET_W-1:0] stop_offset;
    logic                           ended_by_nul;

    modport source (output valid, output string_valid, output stop_offset,
                    output ended_by_nul, input ready);
    modport sink   (input valid, input string_valid, input stop_offset,
                    input ended_by_nul, output ready);
endinterface

[src/utf8v_scan.sv]
// decoder state and per-byte next-state logic of the utf8 stream validator
`timescale 1ns / 1ps

module utf8v_scan #(
    parameter int POSITION_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic                          i_cfg_wdata,
    input  logic                          i_step,
    input  logic [utf8v_pkg::BYTE_W-1:0]  i_data_byte,
    input  logic                          i_last_byte,
    output utf8v_pkg::t_result            o_result
);
    import utf8v_pkg::*;

    logic                     r_mode;
    logic [1:0]               r_cont, n_cont;
    logic [CP_W-1:0]          r_cp, n_cp;
    logic [1:0]               r_kind, n_kind;
    logic [POSITION_BITS-1:0] r_pos, n_pos;
    logic [POSITION_BITS-1:0] r_start, n_start;
    logic                     r_stopped, n_stopped;
    logic                     r_failed, n_failed;
    logic [POSITION_BITS-1:0] r_stop_off, n_stop_off;
    logic                     r_by_nul, n_by_nul;

    logic [CP_W-1:0]          cp_shift;
    logic [1:0]               cont_dec;
    logic [POSITION_BITS-1:0] pos_next;
    logic [OFFSET_W-1:0]      off_out;
    logic                     end_failed;
    logic                     end_by_nul;
    logic [POSITION_BITS-1:0] end_off;

    always_comb begin
        n_cont     = r_cont;
        n_cp       = r_cp;
        n_kind     = r_kind;
        n_pos      = r_pos;
        n_start    = r_start;
        n_stopped  = r_stopped;
        n_failed   = r_failed;
        n_stop_off = r_stop_off;
        n_by_nul   = r_by_nul;
        cp_shift   = {r_cp[CP_W-7:0], i_data_byte[5:0]};
        cont_dec   = r_cont - 2'd1;
        pos_next   = (&r_pos) ? r_pos : r_pos + 1'b1;

        if (!r_stopped) begin
            if (r_cont != 2'd0) begin
                if (i_data_byte[7:6] != 2'b10) begin
                    n_stopped  = 1'b1;
                    n_failed   = 1'b1;
                    n_stop_off = r_start;
                    n_cont     = 2'd0;
                end else begin
                    n_cp   = cp_shift;
                    n_cont = cont_dec;
                    if (cont_dec == 2'd0 && r_kind >= KIND_THREE && !cp_ok(cp_shift, r_kind)) begin
                        n_stopped  = 1'b1;
                        n_failed   = 1'b1;
                        n_stop_off = r_start;
                    end
                end
            end else if (i_data_byte == '0) begin
                // nul outside a sequence ends the scan
                n_stopped  = 1'b1;
                n_by_nul   = 1'b1;
                n_stop_off = r_pos;
                n_failed   = !r_mode;
            end else if (!i_data_byte[7]) begin
                n_cont = 2'd0;
            end else if (i_data_byte[7:5] == 3'b110) begin
                if (i_data_byte[4:1] == 4'd0) begin
                    n_stopped  = 1'b1;
                    n_failed   = 1'b1;
                    n_stop_off = r_pos;
                end else begin
                    n_kind  = KIND_TWO;
                    n_cont  = 2'd1;
                    n_cp    = CP_W'(i_data_byte[4:0]);
                    n_start = r_pos;
                end
            end else if (i_data_byte[7:4] == 4'b1110) begin
                n_kind  = KIND_THREE;
                n_cont  = 2'd2;
                n_cp    = CP_W'(i_data_byte[3:0]);
                n_start = r_pos;
            end else if (i_data_byte[7:3] == 5'b11110) begin
                n_kind  = KIND_FOUR;
                n_cont  = 2'd3;
                n_cp    = CP_W'(i_data_byte[2:0]);
                n_start = r_pos;
            end else begin
                n_stopped  = 1'b1;
                n_failed   = 1'b1;
                n_stop_off = r_pos;
            end
        end

        // frame end closes the string
        if (i_last_byte && !n_stopped) begin
            if (n_cont != 2'd0) begin
                n_failed   = 1'b1;
                n_stop_off = n_start;
            end else begin
                n_stop_off = pos_next;
            end
        end

        end_failed = n_failed;
        end_off    = n_stop_off;
        end_by_nul = n_by_nul;

        if (i_last_byte) begin
            n_cont     = 2'd0;
            n_cp       = '0;
            n_kind     = KIND_NONE;
            n_pos      = '0;
            n_start    = '0;
            n_stopped  = 1'b0;
            n_failed   = 1'b0;
            n_stop_off = '0;
            n_by_nul   = 1'b0;
        end else begin
            n_pos = pos_next;
        end
    end

    generate
        if (POSITION_BITS > OFFSET_W) begin : g_sat
            assign off_out = (|end_off[POSITION_BITS-1:OFFSET_W]) ? '1
                                                                  : end_off[OFFSET_W-1:0];
        end else begin : g_ext
            assign off_out = OFFSET_W'(end_off);
        end
    endgenerate

    assign o_result = '{string_valid: !end_failed,
                        stop_offset:  off_out,
                        ended_by_nul: end_by_nul};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode     <= 1'b0;
            r_cont     <= 2'd0;
            r_cp       <= '0;
            r_kind     <= KIND_NONE;
            r_pos      <= '0;
            r_start    <= '0;
            r_stopped  <= 1'b0;
            r_failed   <= 1'b0;
            r_stop_off <= '0;
            r_by_nul   <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                r_mode <= i_cfg_wdata;
            end
            if (i_step) begin
                r_cont     <= n_cont;
                r_cp       <= n_cp;
                r_kind     <= n_kind;
                r_pos      <= n_pos;
                r_start    <= n_start;
                r_stopped  <= n_stopped;
                r_failed   <= n_failed;
                r_stop_off <= n_stop_off;
                r_by_nul   <= n_by_nul;
            end
        end
    end

    a_failed_stops: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_failed |-> r_stopped)
        else $error("failed scan not marked stopped");

    a_open_not_stopped: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_cont != 2'd0) |-> !r_stopped)
        else $error("open sequence after scan stop");

    a_cont_within_kind: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_cont <= r_kind)
        else $error("continuation count exceeds sequence kind");

    a_clear_after_frame: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_step && i_last_byte) |=> (r_pos == '0 && !r_stopped && r_cont == 2'd0))
        else $error("string state not cleared after frame end");

endmodule

[src/utf8v_out_stage.sv]
// result register with valid/ready handshake for the utf8 stream validator
`timescale 1ns / 1ps

module utf8v_out_stage (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  utf8v_pkg::t_result    i_result,
    output logic                  o_free,
    utf8v_result_if.source        o_result
);
    import utf8v_pkg::*;

    logic    r_valid;
    t_result r_data;

    assign o_free                = !r_valid || o_result.ready;
    assign o_result.valid        = r_valid;
    assign o_result.string_valid = r_data.string_valid;
    assign o_result.stop_offset  = r_data.stop_offset;
    assign o_result.ended_by_nul = r_data.ended_by_nul;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_load) begin
            r_valid <= 1'b1;
        end else if (o_result.ready) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_load) begin
            r_data <= i_result;
        end
    end

    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |-> (!r_valid || o_result.ready))
        else $error("pending result overwritten");

    a_load_shows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_load |=> r_valid)
        else $error("loaded result not presented");

    a_drop_only_on_transfer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_valid && !o_result.ready) |=> r_valid)
        else $error("result dropped without transfer");

endmodule

[src/utf8_stream_validator.sv]
// top level of the utf8 stream validator
`timescale 1ns / 1ps

// Checks one string per frame as UTF-8, one byte per transfer, and returns one
// result per frame: validity, the stop offset and whether a NUL ended the scan.
// A byte is taken into an input register, runs from there through the decoder
// logic, and the frame result lands in an output register, so a byte can be
// taken in every cycle unless the input side stalls. The input side stalls
// only while a finished result waits in the output register and the next frame
// end is ready to be decoded. i_cfg_wdata sets NUL-terminated mode (1) or
// full-length mode (0) and must be written between frames. Positions count in
// POSITION_BITS bits and saturate, and the reported offset saturates at 0xFFFF.
module utf8_stream_validator #(
    parameter int POSITION_BITS = 16
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic            i_cfg_wdata,
    utf8v_byte_if.sink      i_byte,
    utf8v_result_if.source  o_result
);
    import utf8v_pkg::*;

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_in_last;
    logic              out_free;
    logic              advance;
    t_result           scan_result;

    assign advance      = r_in_valid && (!r_in_last || out_free);
    assign i_byte.ready = !r_in_valid || advance;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_byte.ready) begin
            r_in_valid <= i_byte.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_byte.valid && i_byte.ready) begin
            r_in_byte <= i_byte.data_byte;
            r_in_last <= i_byte.last_byte;
        end
    end

    utf8v_scan #(
        .POSITION_BITS(POSITION_BITS)
    ) u_scan (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_step      (advance),
        .i_data_byte (r_in_byte),
        .i_last_byte (r_in_last),
        .o_result    (scan_result)
    );

    utf8v_out_stage u_out (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_load   (advance && r_in_last),
        .i_result (scan_result),
        .o_free   (out_free),
        .o_result (o_result)
    );

endmodule
